/* rtl/rwc_pkg.sv */
package rwc_pkg;

  // Ring depth (1 to 64)
  localparam int unsigned ENTRIES = 8;
  localparam int unsigned IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  localparam int unsigned NONCE_W = 32;
  localparam int unsigned GROUP_W = 16;
  localparam int unsigned KIND_W  = 8;

  typedef enum logic [0:0] {
    OP_CHECK = 1'b0,
    OP_CLEAR = 1'b1
  } op_e;

  typedef struct packed {
    logic [NONCE_W-1:0] reader_nonce;
    logic [NONCE_W-1:0] target_nonce;
    logic [GROUP_W-1:0] group;
    logic [KIND_W-1:0]  request_kind;
  } tuple_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;  // latch the accepted transaction
    logic commit;   // apply lookup result to the ring
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic hit;      // tuple matches a valid entry
    logic clear;    // latched op is a clear
  } dp_status_t;

endpackage

/* rtl/rwc_ifs.sv */
interface rwc_req_if;
  import rwc_pkg::*;

  logic                valid;
  logic                ready;
  op_e                 op;
  logic [NONCE_W-1:0]  reader_nonce;
  logic [NONCE_W-1:0]  target_nonce;
  logic [GROUP_W-1:0]  group;
  logic [KIND_W-1:0]   request_kind;

  modport source (
    output valid, op, reader_nonce, target_nonce, group, request_kind,
    input  ready
  );

  modport sink (
    input  valid, op, reader_nonce, target_nonce, group, request_kind,
    output ready
  );
endinterface

interface rwc_rsp_if;
  logic valid;
  logic ready;
  logic fresh;

  modport source (
    output valid, fresh,
    input  ready
  );

  modport sink (
    input  valid, fresh,
    output ready
  );
endinterface

/* rtl/rwc_datapath.sv */
module rwc_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rwc_pkg::ctrl_cmd_t  cmd_i,
  input  rwc_pkg::op_e        op_i,
  input  rwc_pkg::tuple_t     tuple_i,
  output rwc_pkg::dp_status_t status_o
);
  import rwc_pkg::*;

  op_e                op_q;
  tuple_t             tuple_q;
  tuple_t             mem_q [ENTRIES];
  logic [ENTRIES-1:0] valid_q, valid_d;
  logic [IDX_W-1:0]   ptr_q, ptr_d;
  logic [ENTRIES-1:0] match;
  logic               insert;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q    <= op_i;
      tuple_q <= tuple_i;
    end
  end

  // one comparator per entry
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match[i] = valid_q[i] && (mem_q[i] == tuple_q);
    end
  end

  assign status_o.hit   = |match;
  assign status_o.clear = (op_q == OP_CLEAR);

  assign insert = cmd_i.commit && !status_o.clear && !status_o.hit;

  always_comb begin
    valid_d = valid_q;
    ptr_d   = ptr_q;
    if (cmd_i.commit && status_o.clear) begin
      valid_d = '0;
      ptr_d   = '0;
    end else if (insert) begin
      valid_d[ptr_q] = 1'b1;
      ptr_d = (ptr_q == IDX_W'(ENTRIES - 1)) ? '0 : ptr_q + IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      ptr_q   <= '0;
    end else begin
      valid_q <= valid_d;
      ptr_q   <= ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (insert) begin
      mem_q[ptr_q] <= tuple_q;
    end
  end

`ifndef NO_ASSERTIONS
  a_insert_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    insert |=> valid_q[$past(ptr_q)])
    else $error("inserted entry not marked valid");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit && status_o.clear |=> valid_q == '0 && ptr_q == '0)
    else $error("clear left valid entries or pointer");

  a_hit_no_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit && !status_o.clear && status_o.hit |=> $stable(valid_q) && $stable(ptr_q))
    else $error("replay altered the ring");
`endif

endmodule

/* rtl/rwc_ctrl.sv */
module rwc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  output logic                req_ready_o,
  output logic                rsp_valid_o,
  input  logic                rsp_ready_i,
  output logic                fresh_o,
  output rwc_pkg::ctrl_cmd_t  cmd_o,
  input  rwc_pkg::dp_status_t status_i
);
  import rwc_pkg::*;

  typedef enum logic [0:0] {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   fresh_q;
  logic   can_load;

  // result register free, or being drained this cycle
  assign can_load = !out_valid_q || rsp_ready_i;

  assign req_ready_o   = (state_q == S_IDLE);
  assign cmd_o.capture = (state_q == S_IDLE) && req_valid_i;
  assign cmd_o.commit  = (state_q == S_EXEC) && can_load;

  assign rsp_valid_o = out_valid_q;
  assign fresh_o     = fresh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      fresh_q     <= 1'b0;
    end else begin
      // a new result replaces one that drains in the same cycle
      if (cmd_o.commit) begin
        out_valid_q <= 1'b1;
        fresh_q     <= !status_i.clear && !status_i.hit;
      end else if (out_valid_q && rsp_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (req_valid_i) begin
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (can_load) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_commit_loads_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> out_valid_q)
    else $error("commit without result");

  a_capture_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> state_q == S_EXEC)
    else $error("capture did not start lookup");

  a_stall_holds_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EXEC && out_valid_q && !rsp_ready_i |=> state_q == S_EXEC)
    else $error("lookup left while result blocked");
`endif

endmodule

/* rtl/replay_window_cache.sv */
// Replay window cache: keeps the last rwc_pkg::ENTRIES message tuples
// (reader nonce, target nonce, group, request kind) in a ring. A check
// transaction (op = OP_CHECK) returns fresh = 1 and stores the tuple over the
// oldest slot when no valid entry matches, or fresh = 0 and leaves the ring
// untouched on a replay. A clear transaction (op = OP_CLEAR) drops every entry,
// rewinds the ring pointer and returns fresh = 0. Every request gives exactly
// one response. A request is first registered; then all entries are compared
// in parallel and the ring is updated, and the input takes no new transaction
// until that lookup has completed. The response
// sits in an output register, so a new request is taken while the previous
// response waits; if that response is still not taken when the next lookup
// completes, the lookup holds until it drains. No clearing pass after reset:
// entry valid bits reset at once and the block is ready as soon as reset ends.
module replay_window_cache (
  input  logic clk_i,
  input  logic rst_ni,
  rwc_req_if.sink   req_i,
  rwc_rsp_if.source rsp_o
);
  import rwc_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;
  tuple_t     tuple;

  assign tuple.reader_nonce = req_i.reader_nonce;
  assign tuple.target_nonce = req_i.target_nonce;
  assign tuple.group        = req_i.group;
  assign tuple.request_kind = req_i.request_kind;

  // sequencing and response register
  rwc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .fresh_o     (rsp_o.fresh),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  // tuple store, comparators and ring pointer
  rwc_datapath u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .op_i     (req_i.op),
    .tuple_i  (tuple),
    .status_o (status)
  );

endmodule
